[sv/dsac_pkg.sv]
// ----------------------------------------------------------------------------
// dsac_pkg
// Shared types, codes and constants of the delta-modulation sample channel.
// ----------------------------------------------------------------------------
`default_nettype none

package dsac_pkg;

  // Item commands
  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_ENABLE  = 3'd1,
    CMD_DISABLE = 3'd2,
    CMD_LOAD    = 3'd3,
    CMD_FETCHED = 3'd4
  } cmd_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_INDEX   = 3'd0,
    REG_LOOP_ENABLE  = 3'd1,
    REG_IRQ_ARM      = 3'd2,
    REG_START_PAGE   = 3'd3,
    REG_LENGTH_UNITS = 3'd4
  } cfg_reg_t;

  localparam logic [15:0] START_BASE    = 16'hC000;
  localparam logic [15:0] WRAP_ADDR     = 16'h8000;
  localparam logic [15:0] LAST_ADDR     = 16'hFFFF;
  localparam logic [6:0]  LEVEL_UP_MAX  = 7'd125;
  localparam logic [6:0]  LEVEL_DN_MIN  = 7'd2;
  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

  // Sample buffer status, reader to output unit
  typedef struct packed {
    logic       full;
    logic [7:0] data;
  } buf_status_t;

  // One result item
  typedef struct packed {
    logic [6:0]  level_out;
    logic        irq_pending;
    logic        fetch_request;
    logic [15:0] fetch_address;
    logic [11:0] bytes_left;
  } result_t;

  // Timer period in ticks for each rate index
  function automatic logic [8:0] rate_period(input logic [3:0] idx);
    logic [8:0] p;
    case (idx)
      4'd0:    p = 9'd428;
      4'd1:    p = 9'd380;
      4'd2:    p = 9'd340;
      4'd3:    p = 9'd320;
      4'd4:    p = 9'd286;
      4'd5:    p = 9'd254;
      4'd6:    p = 9'd226;
      4'd7:    p = 9'd214;
      4'd8:    p = 9'd190;
      4'd9:    p = 9'd160;
      4'd10:   p = 9'd142;
      4'd11:   p = 9'd128;
      4'd12:   p = 9'd106;
      4'd13:   p = 9'd84;
      4'd14:   p = 9'd72;
      default: p = 9'd54;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[sv/dsac_if.sv]
// ----------------------------------------------------------------------------
// dsac_if
// Valid/ready channels of the channel: items in, results out, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsac_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [6:0] level_value;
  logic [7:0] fetched_byte;

  modport source (output valid, command, level_value, fetched_byte, input ready);
  modport sink   (input valid, command, level_value, fetched_byte, output ready);
endinterface

interface dsac_result_if;
  logic        valid;
  logic        ready;
  logic [6:0]  level_out;
  logic        irq_pending;
  logic        fetch_request;
  logic [15:0] fetch_address;
  logic [11:0] bytes_left;

  modport source (output valid, level_out, irq_pending, fetch_request,
                  fetch_address, bytes_left, input ready);
  modport sink   (input valid, level_out, irq_pending, fetch_request,
                  fetch_address, bytes_left, output ready);
endinterface

interface dsac_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/dsac_output_unit.sv]
// ----------------------------------------------------------------------------
// dsac_output_unit
// Rate timer, shift register and 7-bit delta level.
// ----------------------------------------------------------------------------
`default_nettype none

module dsac_output_unit import dsac_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        tick,
  input  wire logic        load,
  input  wire logic [6:0]  level_value,
  input  wire logic [3:0]  rate_index,
  input  wire buf_status_t buf_status,
  output logic             reload,
  output logic [6:0]       level_next
);

  logic [8:0] timer_count, timer_next, timer_inc;
  logic [7:0] shift_bits, shift_next;
  logic [3:0] bits_left, bits_next, bits_dec;
  logic       silent, silent_next;
  logic [6:0] level, level_step;
  logic       expire;

  always_comb begin
    timer_inc = timer_count + 9'd1;
    expire    = tick && (timer_inc >= rate_period(rate_index));
    bits_dec  = bits_left - 4'd1;

    // Step the level unless silent, clamped at both ends
    level_step = level;
    if (!silent) begin
      if (shift_bits[0]) begin
        if (level <= LEVEL_UP_MAX) level_step = level + 7'd2;
      end else begin
        if (level >= LEVEL_DN_MIN) level_step = level - 7'd2;
      end
    end

    timer_next  = timer_count;
    shift_next  = shift_bits;
    bits_next   = bits_left;
    silent_next = silent;
    reload      = 1'b0;
    if (tick) timer_next = timer_inc;
    if (expire) begin
      timer_next = '0;
      shift_next = shift_bits >> 1;
      bits_next  = bits_dec;
      if (bits_dec == 4'd0) begin
        bits_next = BITS_PER_BYTE;
        if (buf_status.full) begin
          reload      = 1'b1;
          silent_next = 1'b0;
          shift_next  = buf_status.data;
        end else begin
          silent_next = 1'b1;
        end
      end
    end

    if (load)        level_next = level_value;
    else if (expire) level_next = level_step;
    else             level_next = level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_count <= '0;
      shift_bits  <= '0;
      bits_left   <= BITS_PER_BYTE;
      silent      <= 1'b1;
      level       <= '0;
    end else begin
      timer_count <= timer_next;
      shift_bits  <= shift_next;
      bits_left   <= bits_next;
      silent      <= silent_next;
      level       <= level_next;
    end
  end

endmodule

`default_nettype wire

[sv/dsac_reader.sv]
// ----------------------------------------------------------------------------
// dsac_reader
// Memory reader: sample buffer, fetch address, byte count and IRQ flag.
// ----------------------------------------------------------------------------
`default_nettype none

module dsac_reader import dsac_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   enable,
  input  wire logic   disable_ch,
  input  wire logic   fetched,
  input  wire logic [7:0] fetched_byte,
  input  wire logic   reload,
  input  wire logic   irq_clear,
  input  wire logic   loop_enable,
  input  wire logic   irq_arm,
  input  wire logic [7:0] start_page,
  input  wire logic [7:0] length_units,
  output buf_status_t buf_status,
  output logic        irq_next,
  output logic        fetch_request_next,
  output logic [15:0] address_next,
  output logic [11:0] remaining_next
);

  logic        buffer_full, full_next;
  logic [7:0]  buffer_byte, byte_next;
  logic [15:0] current_address;
  logic [11:0] remaining_bytes, remaining_dec;
  logic        irq_flag;
  logic        take;
  logic [15:0] start_addr;
  logic [11:0] start_len;

  assign buf_status = '{full: buffer_full, data: buffer_byte};

  always_comb begin
    start_addr    = START_BASE + {2'b00, start_page, 6'b000000};
    start_len     = {length_units, 4'b0000} + 12'd1;
    remaining_dec = remaining_bytes - 12'd1;
    take          = fetched && !buffer_full && (remaining_bytes != 12'd0);

    full_next      = buffer_full;
    byte_next      = buffer_byte;
    address_next   = current_address;
    remaining_next = remaining_bytes;
    irq_next       = irq_flag;

    if (reload) full_next = 1'b0;
    if (irq_clear) irq_next = 1'b0;

    if (enable) begin
      irq_next = 1'b0;
      if (remaining_bytes == 12'd0) begin
        address_next   = start_addr;
        remaining_next = start_len;
      end
    end

    if (disable_ch) begin
      irq_next       = 1'b0;
      remaining_next = '0;
    end

    if (take) begin
      full_next      = 1'b1;
      byte_next      = fetched_byte;
      address_next   = (current_address == LAST_ADDR) ? WRAP_ADDR
                                                      : current_address + 16'd1;
      remaining_next = remaining_dec;
      // Sample end: loop back or flag the interrupt
      if (remaining_dec == 12'd0) begin
        if (loop_enable) begin
          address_next   = start_addr;
          remaining_next = start_len;
        end else if (irq_arm) begin
          irq_next = 1'b1;
        end
      end
    end

    fetch_request_next = !full_next && (remaining_next != 12'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_full     <= 1'b0;
      buffer_byte     <= '0;
      current_address <= START_BASE;
      remaining_bytes <= '0;
      irq_flag        <= 1'b0;
    end else begin
      buffer_full     <= full_next;
      buffer_byte     <= byte_next;
      current_address <= address_next;
      remaining_bytes <= remaining_next;
      irq_flag        <= irq_next;
    end
  end

endmodule

`default_nettype wire

[sv/delta_sample_audio_channel.sv]
// ----------------------------------------------------------------------------
// delta_sample_audio_channel
// Delta-modulation sample channel with memory reader and rate timer.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle on in_item while results are taken and gives
// exactly one result per item on out_result in the cycle after the transfer.
// The whole update of an item (timer compare, level step, buffer and address
// bookkeeping) sits between the channel state registers and a single result
// register, so the sustained rate is one item per cycle for as long as the
// result side keeps taking transfers. in_item.ready drops only while a result
// is held and not taken. Register writes on cfg are always ready and are
// registered; a write to an index past the last register is taken and dropped.
// No clearing pass runs after reset: items are accepted once rst is released.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_sample_audio_channel import dsac_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  dsac_item_if.sink     in_item,
  dsac_result_if.source out_result,
  dsac_cfg_if.sink      cfg
);

  // Configuration registers
  logic [3:0] rate_index;
  logic       loop_enable;
  logic       irq_arm;
  logic [7:0] start_page;
  logic [7:0] length_units;

  logic        in_xfer, cfg_xfer;
  cmd_t        cmd;
  logic        irq_clear;
  logic        reload;
  buf_status_t buf_status;
  result_t     result_next, result;
  logic        out_valid;

  assign in_xfer  = in_item.valid && in_item.ready;
  assign cfg_xfer = cfg.valid && cfg.ready;
  assign cmd      = cmd_t'(in_item.command);

  // Accept while the result register is empty or being drained
  assign in_item.ready = !out_valid || out_result.ready;
  assign cfg.ready     = 1'b1;

  // Writing zero to irq_arm drops a raised interrupt at once
  assign irq_clear = cfg_xfer && (cfg_reg_t'(cfg.index) == REG_IRQ_ARM) && !cfg.data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_index   <= '0;
      loop_enable  <= 1'b0;
      irq_arm      <= 1'b0;
      start_page   <= '0;
      length_units <= '0;
    end else if (cfg_xfer) begin
      case (cfg_reg_t'(cfg.index))
        REG_RATE_INDEX:   rate_index   <= cfg.data[3:0];
        REG_LOOP_ENABLE:  loop_enable  <= cfg.data[0];
        REG_IRQ_ARM:      irq_arm      <= cfg.data[0];
        REG_START_PAGE:   start_page   <= cfg.data;
        REG_LENGTH_UNITS: length_units <= cfg.data;
        default: ;
      endcase
    end
  end

  dsac_output_unit u_output_unit (
    .clk         (clk),
    .rst         (rst),
    .tick        (in_xfer && (cmd == CMD_TICK)),
    .load        (in_xfer && (cmd == CMD_LOAD)),
    .level_value (in_item.level_value),
    .rate_index  (rate_index),
    .buf_status  (buf_status),
    .reload      (reload),
    .level_next  (result_next.level_out)
  );

  dsac_reader u_reader (
    .clk                (clk),
    .rst                (rst),
    .enable             (in_xfer && (cmd == CMD_ENABLE)),
    .disable_ch         (in_xfer && (cmd == CMD_DISABLE)),
    .fetched            (in_xfer && (cmd == CMD_FETCHED)),
    .fetched_byte       (in_item.fetched_byte),
    .reload             (reload),
    .irq_clear          (irq_clear),
    .loop_enable        (loop_enable),
    .irq_arm            (irq_arm),
    .start_page         (start_page),
    .length_units       (length_units),
    .buf_status         (buf_status),
    .irq_next           (result_next.irq_pending),
    .fetch_request_next (result_next.fetch_request),
    .address_next       (result_next.fetch_address),
    .remaining_next     (result_next.bytes_left)
  );

  // Result register: capture the post-item state, hold until transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      result <= result_next;
    end
  end

  assign out_result.valid         = out_valid;
  assign out_result.level_out     = result.level_out;
  assign out_result.irq_pending   = result.irq_pending;
  assign out_result.fetch_request = result.fetch_request;
  assign out_result.fetch_address = result.fetch_address;
  assign out_result.bytes_left    = result.bytes_left;

endmodule

`default_nettype wire

[sv/dsac_checker.sv]
// ----------------------------------------------------------------------------
// dsac_checker
// Port-level checks of the sample channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dsac_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_fetch_request,
  input wire logic [15:0] out_fetch_address,
  input wire logic [11:0] out_bytes_left
);

  // A held result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // Every accepted item yields a result on the next cycle
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

  // Fetch addresses stay in the upper half of the address space
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_fetch_address[15])
    else $error("fetch address below 0x8000");

  // A fetch is only requested while sample bytes remain
  a_req_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_fetch_request |-> out_bytes_left != 12'd0)
    else $error("fetch requested with no bytes left");

endmodule

bind delta_sample_audio_channel dsac_checker u_dsac_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_item.valid),
  .in_ready          (in_item.ready),
  .out_valid         (out_result.valid),
  .out_ready         (out_result.ready),
  .out_fetch_request (out_result.fetch_request),
  .out_fetch_address (out_result.fetch_address),
  .out_bytes_left    (out_result.bytes_left)
);

`default_nettype wire
